FILE: rtl/dse_pkg.sv
// ============================================================================
// dse_pkg : shared types and constants for the date string converter
// Character codes, calendar constants, parser state and the month table.
// ============================================================================
package dse_pkg;

    // Character codes
    localparam logic [7:0] CHAR_0 = 8'h30;
    localparam logic [7:0] CHAR_9 = 8'h39;
    localparam logic [7:0] CHAR_P = 8'h70;

    // Configuration register indexes
    localparam logic CFG_CURRENT_YEAR = 1'b0;
    localparam logic CFG_TZ_OFFSET    = 1'b1;

    // Pair positions in the string
    localparam logic [2:0] PAIR_MONTH  = 3'd0;
    localparam logic [2:0] PAIR_DAY    = 3'd1;
    localparam logic [2:0] PAIR_HOUR   = 3'd2;
    localparam logic [2:0] PAIR_MINUTE = 3'd3;
    localparam logic [2:0] PAIR_YEAR   = 3'd4;
    localparam logic [2:0] PAIRS_ALL   = 3'd5;

    // Calendar constants
    localparam int unsigned EPOCH_YEAR = 1970;
    localparam int unsigned BASE_YEAR  = 1900;
    localparam logic [7:0]  EPOCH_OFS  = 8'(EPOCH_YEAR - BASE_YEAR);
    localparam logic [7:0]  CENTURY_NONLEAP_A = 8'd0;   // 1900
    localparam logic [7:0]  CENTURY_NONLEAP_B = 8'd200; // 2100
    localparam logic [8:0]  DAYS_YEAR  = 9'd365;
    localparam logic [8:0]  DAYS_LEAP  = 9'd366;
    localparam logic [3:0]  MONTH_FEB  = 4'd2;
    localparam logic [6:0]  MAX_MONTH  = 7'd12;
    localparam logic [6:0]  MAX_DAY    = 7'd31;
    localparam logic [6:0]  HOUR_WRAP  = 7'd24;
    localparam logic [6:0]  MAX_MINUTE = 7'd59;
    localparam logic [5:0]  MAX_HOUR   = 6'd23;
    localparam logic [5:0]  PM_HOURS   = 6'd12;
    localparam logic [5:0]  HOURS_PER_DAY = 6'd24;
    localparam logic [5:0]  MIN_PER_HOUR  = 6'd60;
    localparam logic [5:0]  SEC_PER_MIN   = 6'd60;
    localparam logic [5:0]  MUL_ONE       = 6'd1;

    // Parser state, also handed to the sequencer when a string ends
    typedef struct packed {
        logic [2:0] pair_index;
        logic       parse_stopped;
        logic [3:0] held_digit;
        logic       held_valid;
        logic [7:0] cursor_char;
        logic [3:0] month_val;
        logic [5:0] day_val;
        logic [5:0] hour_val;
        logic [5:0] minute_val;
        logic [7:0] year_val;
        logic       year_given;
    } parse_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_YEARS,
        S_MONTHS,
        S_DAY,
        S_HOUR,
        S_MIN,
        S_SEC,
        S_FIN
    } calc_state_t;

    // Month lengths, February short; index is the month number 1..12
    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] len;
        begin
            case (m)
                4'd2:                    len = 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
                default:                 len = 5'd31;
            endcase
            return len;
        end
    endfunction

    // Gregorian leap test on years since 1900 (range 1900..2155)
    function automatic logic leap_ofs(input logic [7:0] yr);
        begin
            return (yr[1:0] == 2'b00) && (yr != CENTURY_NONLEAP_A)
                && (yr != CENTURY_NONLEAP_B);
        end
    endfunction

endpackage

FILE: rtl/dse_parse.sv
// ============================================================================
// dse_parse : character parser
// Collects digit pairs of an MMDDhhmm[yy][p] string one character a cycle while accept is high.
// ============================================================================
module dse_parse
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [7:0]      char_in,
    input  logic            last,
    output dse_pkg::parse_t pnext
);

    dse_pkg::parse_t p_reg;
    dse_pkg::parse_t p_next;

    logic       digit;
    logic [3:0] dval;
    logic [6:0] pair_v;
    logic       pair_ok;

    // Pair value and range check for the current position
    always_comb
    begin
        digit  = char_in inside {[dse_pkg::CHAR_0:dse_pkg::CHAR_9]};
        dval   = char_in[3:0];
        pair_v = {p_reg.held_digit, 3'b000} + {2'b00, p_reg.held_digit, 1'b0}
               + {3'b000, dval};
        case (p_reg.pair_index)
            dse_pkg::PAIR_MONTH:  pair_ok = (pair_v >= 7'd1) && (pair_v <= dse_pkg::MAX_MONTH);
            dse_pkg::PAIR_DAY:    pair_ok = (pair_v >= 7'd1) && (pair_v <= dse_pkg::MAX_DAY);
            dse_pkg::PAIR_HOUR:   pair_ok = (pair_v <= dse_pkg::HOUR_WRAP);
            dse_pkg::PAIR_MINUTE: pair_ok = (pair_v <= dse_pkg::MAX_MINUTE);
            default:              pair_ok = 1'b1;
        endcase
    end

    // State after feeding this character
    always_comb
    begin
        p_next = p_reg;
        if (!p_reg.parse_stopped)
        begin
            if (p_reg.pair_index >= dse_pkg::PAIRS_ALL)
            begin
                p_next.cursor_char   = char_in;
                p_next.parse_stopped = 1'b1;
            end
            else if (!p_reg.held_valid)
            begin
                if (digit)
                begin
                    p_next.held_digit = dval;
                    p_next.held_valid = 1'b1;
                end
                else
                begin
                    p_next.cursor_char   = char_in;
                    p_next.parse_stopped = 1'b1;
                end
            end
            else
            begin
                p_next.held_valid = 1'b0;
                if (digit && pair_ok)
                begin
                    case (p_reg.pair_index)
                        dse_pkg::PAIR_MONTH:  p_next.month_val  = pair_v[3:0];
                        dse_pkg::PAIR_DAY:    p_next.day_val    = pair_v[5:0];
                        dse_pkg::PAIR_HOUR:   p_next.hour_val   = pair_v[5:0];
                        dse_pkg::PAIR_MINUTE: p_next.minute_val = pair_v[5:0];
                        default:
                        begin
                            p_next.year_val   = {1'b0, pair_v};
                            p_next.year_given = 1'b1;
                        end
                    endcase
                    p_next.pair_index = p_reg.pair_index + 3'd1;
                end
                else
                begin
                    p_next.cursor_char   = {4'h3, p_reg.held_digit};
                    p_next.parse_stopped = 1'b1;
                end
            end
        end
    end

    // Parser register, cleared once a string ends
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg <= '0;
        end
        else if (accept)
        begin
            if (last)
                p_reg <= '0;
            else
                p_reg <= p_next;
        end
    end

    assign pnext = p_next;

endmodule

FILE: rtl/dse_mac.sv
// ============================================================================
// dse_mac : shared multiply-add unit
// result = acc * mul + addend, modulo 2^32.
// ============================================================================
module dse_mac
(
    input  logic [31:0] acc,
    input  logic [5:0]  mul,
    input  logic [31:0] addend,
    output logic [31:0] result
);

    logic [37:0] prod;

    always_comb
    begin
        prod   = {6'b0, acc} * {32'b0, mul};
        result = prod[31:0] + addend;
    end

endmodule

FILE: rtl/dse_calc.sv
// ============================================================================
// dse_calc : conversion sequencer
// Walks years and months through the shared multiply-add unit, scales to
// seconds, adds the zone offset and holds the result for the output side.
// ============================================================================
module dse_calc
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  dse_pkg::parse_t pdone,
    input  logic [7:0]      current_year,
    input  logic [16:0]     tz_offset,
    output logic            idle,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [31:0]     seconds,
    output logic            bad
);

    dse_pkg::calc_state_t state_reg, state_next;

    logic [31:0] acc_reg, acc_next;
    logic [7:0]  cnt_reg, cnt_next;
    logic [7:0]  eff_yr_reg, eff_yr_next;
    logic        leap_reg, leap_next;
    logic [3:0]  month_reg, month_next;
    logic [5:0]  day_reg, day_next;
    logic [4:0]  hour_reg, hour_next;
    logic [5:0]  minute_reg, minute_next;
    logic        badw_reg, badw_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] seconds_reg, seconds_next;
    logic        bad_out_reg, bad_out_next;

    logic [5:0]  mac_mul;
    logic [31:0] mac_add;
    logic [31:0] mac_res;

    logic        hour_wrap;
    logic [5:0]  st_hour;
    logic [5:0]  st_day;
    logic [7:0]  st_yr;
    logic        st_bad;
    logic        load;

    dse_mac u_mac
    (
        .acc    (acc_reg),
        .mul    (mac_mul),
        .addend (mac_add),
        .result (mac_res)
    );

    // Start values: hour wrap, afternoon mark, year choice
    always_comb
    begin
        hour_wrap = (pdone.hour_val == dse_pkg::HOUR_WRAP[5:0]);
        st_hour   = hour_wrap ? 6'd0 : pdone.hour_val;
        st_day    = pdone.day_val + {5'd0, hour_wrap};
        if (pdone.cursor_char == dse_pkg::CHAR_P)
            st_hour = st_hour + dse_pkg::PM_HOURS;
        st_bad = (pdone.pair_index < dse_pkg::PAIR_YEAR) || (st_hour > dse_pkg::MAX_HOUR);
        st_yr  = pdone.year_given ? pdone.year_val : current_year;
        if (st_yr < dse_pkg::EPOCH_OFS)
            st_yr = dse_pkg::EPOCH_OFS;
    end

    assign load = (state_reg == dse_pkg::S_FIN) && (!out_valid_reg || out_ready);

    // Sequencer and operand selection
    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        eff_yr_next    = eff_yr_reg;
        leap_next      = leap_reg;
        month_next     = month_reg;
        day_next       = day_reg;
        hour_next      = hour_reg;
        minute_next    = minute_reg;
        badw_next      = badw_reg;
        seconds_next   = seconds_reg;
        bad_out_next   = bad_out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        mac_mul        = dse_pkg::MUL_ONE;
        mac_add        = '0;

        case (state_reg)
            dse_pkg::S_IDLE:
            begin
                if (start)
                begin
                    acc_next    = '0;
                    cnt_next    = dse_pkg::EPOCH_OFS;
                    eff_yr_next = st_yr;
                    leap_next   = dse_pkg::leap_ofs(st_yr);
                    month_next  = pdone.month_val;
                    day_next    = st_day;
                    hour_next   = st_hour[4:0];
                    minute_next = pdone.minute_val;
                    badw_next   = st_bad;
                    state_next  = st_bad ? dse_pkg::S_FIN : dse_pkg::S_YEARS;
                end
            end
            // one whole year per cycle
            dse_pkg::S_YEARS:
            begin
                if (cnt_reg == eff_yr_reg)
                begin
                    cnt_next   = 8'd1;
                    state_next = dse_pkg::S_MONTHS;
                end
                else
                begin
                    mac_add  = {23'd0, dse_pkg::leap_ofs(cnt_reg) ? dse_pkg::DAYS_LEAP
                                                                  : dse_pkg::DAYS_YEAR};
                    acc_next = mac_res;
                    cnt_next = cnt_reg + 8'd1;
                end
            end
            // one whole month per cycle
            dse_pkg::S_MONTHS:
            begin
                if (cnt_reg >= {4'd0, month_reg})
                begin
                    state_next = dse_pkg::S_DAY;
                end
                else
                begin
                    mac_add  = {27'd0, dse_pkg::month_len(cnt_reg[3:0])}
                             + {31'd0, leap_reg && (cnt_reg[3:0] == dse_pkg::MONTH_FEB)};
                    acc_next = mac_res;
                    cnt_next = cnt_reg + 8'd1;
                end
            end
            dse_pkg::S_DAY:
            begin
                mac_add    = {26'd0, day_reg - 6'd1};
                acc_next   = mac_res;
                state_next = dse_pkg::S_HOUR;
            end
            dse_pkg::S_HOUR:
            begin
                mac_mul    = dse_pkg::HOURS_PER_DAY;
                mac_add    = {27'd0, hour_reg};
                acc_next   = mac_res;
                state_next = dse_pkg::S_MIN;
            end
            dse_pkg::S_MIN:
            begin
                mac_mul    = dse_pkg::MIN_PER_HOUR;
                mac_add    = {26'd0, minute_reg};
                acc_next   = mac_res;
                state_next = dse_pkg::S_SEC;
            end
            dse_pkg::S_SEC:
            begin
                mac_mul    = dse_pkg::SEC_PER_MIN;
                acc_next   = mac_res;
                state_next = dse_pkg::S_FIN;
            end
            // zone offset, then into the output register once it is free
            dse_pkg::S_FIN:
            begin
                mac_add = {{15{tz_offset[16]}}, tz_offset};
                if (load)
                begin
                    seconds_next   = badw_reg ? 32'd0 : mac_res;
                    bad_out_next   = badw_reg;
                    out_valid_next = 1'b1;
                    state_next     = dse_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = dse_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dse_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and result registers
    always_ff @(posedge clk)
    begin
        acc_reg     <= acc_next;
        cnt_reg     <= cnt_next;
        eff_yr_reg  <= eff_yr_next;
        leap_reg    <= leap_next;
        month_reg   <= month_next;
        day_reg     <= day_next;
        hour_reg    <= hour_next;
        minute_reg  <= minute_next;
        badw_reg    <= badw_next;
        seconds_reg <= seconds_next;
        bad_out_reg <= bad_out_next;
    end

    assign idle      = (state_reg == dse_pkg::S_IDLE);
    assign out_valid = out_valid_reg;
    assign seconds   = seconds_reg;
    assign bad       = bad_out_reg;

`ifndef SYNTH
    a_year_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dse_pkg::S_YEARS) |-> (cnt_reg <= eff_yr_reg))
        else $error("year counter passed the target year");

    a_month_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dse_pkg::S_MONTHS) |-> (cnt_reg <= 8'd12))
        else $error("month counter past December");

    a_fin_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (out_valid_reg && (state_reg == dse_pkg::S_IDLE)))
        else $error("finished conversion not delivered");

    a_bad_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && bad_out_reg) |-> (seconds_reg == 32'd0))
        else $error("bad string with non-zero seconds");
`endif

endmodule

FILE: rtl/date_string_to_epoch_seconds.sv
// ============================================================================
// date_string_to_epoch_seconds : MMDDhhmm[yy][p] string to Unix seconds
// Parses the string one character a request, then converts the date with a
// shared multiply-add unit under a small sequencer.
// ============================================================================
//
//  channel  | signals                                   | role
//  ---------+-------------------------------------------+--------------------------
//  in       | in_valid, in_ready, char_in, last         | one character per request
//  out      | out_valid, out_ready, seconds, bad        | one result per string
//  cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data | current_year, tz_offset
//
//  Characters are taken one a cycle while the sequencer is idle. A request with
//  last starts a conversion: one step per year and per month walked plus one to
//  leave each walk, four scaling steps and one zone offset step; a failed string
//  goes straight to the zone offset step. No input is taken meanwhile. A stalled
//  output holds the sequencer in its last step once a second result is ready.
//  Reset: idle, current_year 70, tz_offset 0.
//
module date_string_to_epoch_seconds
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_in,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] seconds,
    output logic        bad,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [16:0] cfg_data
);

    dse_pkg::parse_t pnext;

    logic        accept;
    logic        idle;
    logic [7:0]  current_year_reg;
    logic [16:0] tz_offset_reg;

    assign in_ready  = idle;
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_year_reg <= dse_pkg::EPOCH_OFS;
            tz_offset_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                dse_pkg::CFG_CURRENT_YEAR: current_year_reg <= cfg_data[7:0];
                dse_pkg::CFG_TZ_OFFSET:    tz_offset_reg    <= cfg_data;
                default:                   tz_offset_reg    <= tz_offset_reg;
            endcase
        end
    end

    dse_parse u_parse
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .char_in (char_in),
        .last    (last),
        .pnext   (pnext)
    );

    dse_calc u_calc
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (accept && last),
        .pdone        (pnext),
        .current_year (current_year_reg),
        .tz_offset    (tz_offset_reg),
        .idle         (idle),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .seconds      (seconds),
        .bad          (bad)
    );

endmodule

FILE: tb/date_string_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// date_string_checker : scoreboard for the date string converter
// Watches the character, result and register channels, keeps its own copy of
// the parser and the two registers, predicts one conversion per string and
// compares every result request field by field against the oldest prediction.
// ============================================================================
module date_string_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  char_in,
    input  logic        last,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] seconds,
    input  logic        bad,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [16:0] cfg_data,
    output int          fail_count,
    output int          outstanding,
    output int          result_count
);

    typedef struct packed {
        logic [31:0] seconds;
        logic        bad;
    } epoch_result_t;

    localparam int MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    // Register copies
    logic [7:0]         base_year;
    logic signed [16:0] zone_ofs;

    // Parser copy
    logic [2:0] pair_idx;
    logic       stopped;
    logic [3:0] held;
    logic       held_ok;
    logic [7:0] cursor;
    logic [3:0] mon;
    logic [5:0] dy;
    logic [5:0] hr;
    logic [5:0] mn;
    logic [7:0] yr;
    logic       yr_given;

    epoch_result_t expected_times[$];

    initial
    begin
        fail_count   = 0;
        result_count = 0;
        outstanding  = 0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        begin
            fail_count++;
            $display("MISMATCH at %0t, result %0d: %s got %0d, expected %0d",
                     $realtime, result_count, what, got, want);
        end
    endtask

    function automatic void clear_parse();
        pair_idx = '0;
        stopped  = 1'b0;
        held     = '0;
        held_ok  = 1'b0;
        cursor   = '0;
        mon      = '0;
        dy       = '0;
        hr       = '0;
        mn       = '0;
        yr       = '0;
        yr_given = 1'b0;
    endfunction

    function automatic bit leap_year(input int unsigned y);
        return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    function automatic void stop_parse(input logic [7:0] c);
        cursor  = c;
        stopped = 1'b1;
    endfunction

    // Range check on a two digit value at the current pair position
    function automatic bit take_pair(input logic [6:0] v);
        case (pair_idx)
            dse_pkg::PAIR_MONTH:
            begin
                if (v < 1 || v > 12)
                    return 1'b0;
                mon = v[3:0];
            end
            dse_pkg::PAIR_DAY:
            begin
                if (v < 1 || v > 31)
                    return 1'b0;
                dy = v[5:0];
            end
            dse_pkg::PAIR_HOUR:
            begin
                if (v > 24)
                    return 1'b0;
                hr = v[5:0];
            end
            dse_pkg::PAIR_MINUTE:
            begin
                if (v > 59)
                    return 1'b0;
                mn = v[5:0];
            end
            default:
            begin
                yr       = 8'(v);
                yr_given = 1'b1;
            end
        endcase
        return 1'b1;
    endfunction

    function automatic void parse_char(input logic [7:0] c);
        bit is_digit;
        is_digit = (c >= dse_pkg::CHAR_0) && (c <= dse_pkg::CHAR_9);
        if (stopped)
            return;
        // all pairs taken: this character becomes the cursor
        if (pair_idx >= dse_pkg::PAIRS_ALL)
        begin
            stop_parse(c);
            return;
        end
        if (!held_ok)
        begin
            if (is_digit)
            begin
                held    = 4'(c - dse_pkg::CHAR_0);
                held_ok = 1'b1;
            end
            else
                stop_parse(c);
            return;
        end
        held_ok = 1'b0;
        if (is_digit && take_pair(7'(held * 10 + (c - dse_pkg::CHAR_0))))
            pair_idx++;
        else
            stop_parse(dse_pkg::CHAR_0 + 8'(held));   // cursor goes back to the pair's first digit
    endfunction

    // Conversion of the parsed fields to seconds, with the zone offset added
    function automatic epoch_result_t date_to_seconds();
        epoch_result_t r;
        int unsigned   hour_n;
        int unsigned   day_n;
        int unsigned   year_n;
        int unsigned   days;
        int unsigned   y;
        int unsigned   m;
        bit            leap;
        r.seconds = '0;
        r.bad     = 1'b1;
        if (pair_idx < dse_pkg::PAIR_YEAR)
            return r;                       // month, day, hour or minute missing
        hour_n = hr;
        day_n  = dy;
        if (hour_n == 24)
        begin
            hour_n = 0;
            day_n++;
        end
        if (cursor == dse_pkg::CHAR_P)
            hour_n += 12;
        if (hour_n > 23)
            return r;
        year_n = 1900 + (yr_given ? yr : base_year);
        if (year_n < 1970)
            year_n = 1970;
        days = 0;
        for (y = 1970; y < year_n; y++)
            days += leap_year(y) ? 366 : 365;
        leap = leap_year(year_n);
        for (m = 1; m < mon && m <= 12; m++)
            days += MONTH_DAYS[m - 1] + ((leap && m == 2) ? 1 : 0);
        days += day_n - 1;
        r.seconds = ((days * 24 + hour_n) * 60 + mn) * 60;
        r.seconds = r.seconds + {{15{zone_ofs[16]}}, zone_ofs};
        r.bad     = 1'b0;
        return r;
    endfunction

    // Channel monitor: registers, then results, then characters
    always @(posedge clk or negedge rst_n)
    begin
        epoch_result_t want;
        if (!rst_n)
        begin
            base_year = 8'd70;
            zone_ofs  = '0;
            clear_parse();
            expected_times.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == dse_pkg::CFG_CURRENT_YEAR)
                    base_year = cfg_data[7:0];
                else
                    zone_ofs = cfg_data;
            end

            if (out_valid && out_ready)
            begin
                result_count++;
                if (expected_times.size() == 0)
                    report_mismatch("result with no string pending", seconds, 0);
                else
                begin
                    want = expected_times.pop_front();
                    if (seconds !== want.seconds)
                        report_mismatch("seconds", seconds, want.seconds);
                    if (bad !== want.bad)
                        report_mismatch("bad flag", 32'(bad), 32'(want.bad));
                end
            end

            if (in_valid && in_ready)
            begin
                parse_char(char_in);
                if (last)
                begin
                    parse_char(8'h00);       // implicit terminator after the last request
                    expected_times.push_back(date_to_seconds());
                    clear_parse();
                end
            end

            outstanding <= expected_times.size();
        end
    end

endmodule

FILE: tb/tb_date_string_to_epoch_seconds.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_date_string_to_epoch_seconds : stimulus and verdict for the converter
// Sends directed date strings, then random well-formed, damaged and noise
// strings under several register settings and idle patterns, including one
// long output stall; the checker beside the block does all comparison.
// ============================================================================
module tb_date_string_to_epoch_seconds;

    localparam int LIMIT_CYCLES    = 400000;
    localparam int SETTLE_CYCLES   = 300;
    localparam int RANDOM_CHARS    = 450;
    localparam int GROUPS          = 6;
    localparam int PRESSURE_CYCLES = 600;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic [7:0]  char_in   = '0;
    logic        last      = 1'b0;
    logic        out_ready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_index = 1'b0;
    logic [16:0] cfg_data  = '0;
    logic        in_ready;
    logic        out_valid;
    logic        cfg_ready;
    logic [31:0] seconds;
    logic        bad;

    int fail_count;
    int outstanding;
    int result_count;

    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int cycle_count    = 0;
    int chars_sent     = 0;
    int strings_sent   = 0;
    int settings_used  = 1;
    logic hold_go      = 1'b0;
    logic hold_done    = 1'b0;
    int hold_left      = 0;

    logic [7:0] string_buf[$];

    always #5 clk = ~clk;

    date_string_to_epoch_seconds dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .char_in   (char_in),
        .last      (last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .seconds   (seconds),
        .bad       (bad),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    date_string_checker date_check
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .char_in      (char_in),
        .last         (last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .seconds      (seconds),
        .bad          (bad),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .outstanding  (outstanding),
        .result_count (result_count)
    );

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles, %0d results still pending",
                     cycle_count, outstanding);
            $display("Verification failed");
            $finish;
        end
    end

    // Result receiver: random back-pressure, plus one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_go && !hold_done)
        begin
            out_ready <= 1'b0;
            hold_left <= PRESSURE_CYCLES;
            hold_done <= 1'b1;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // One character request; valid drops only across an idle gap
    task automatic send_char(input logic [7:0] c, input logic l);
        int gap;
        begin
            gap = 0;
            while ($urandom_range(0, 99) < send_idle_pct)
                gap++;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid <= 1'b1;
            char_in  <= c;
            last     <= l;
            do
                @(posedge clk);
            while (!in_ready);
            chars_sent++;
        end
    endtask

    task automatic put_text(input string s);
        begin
            for (int i = 0; i < s.len(); i++)
                string_buf.push_back(s[i]);
        end
    endtask

    task automatic put_byte(input logic [7:0] c);
        begin
            string_buf.push_back(c);
        end
    endtask

    // Send the buffered string with last on its final character
    task automatic send_string();
        begin
            if (string_buf.size() == 0)
                string_buf.push_back(8'h00);
            for (int i = 0; i < string_buf.size(); i++)
                send_char(string_buf[i], i == string_buf.size() - 1);
            string_buf.delete();
            strings_sent++;
        end
    endtask

    // Wait until every result is back and the block has gone quiet
    task automatic settle();
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while (outstanding != 0);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    // Both registers in back-to-back requests
    task automatic set_config(input int year_ofs, input int zone);
        begin
            cfg_valid <= 1'b1;
            cfg_index <= dse_pkg::CFG_CURRENT_YEAR;
            cfg_data  <= 17'(year_ofs);
            do
                @(posedge clk);
            while (!cfg_ready);
            cfg_index <= dse_pkg::CFG_TZ_OFFSET;
            cfg_data  <= 17'(zone);
            do
                @(posedge clk);
            while (!cfg_ready);
            cfg_valid <= 1'b0;
            settings_used++;
        end
    endtask

    // Mostly well-formed dates with random fields, some damaged, some noise
    task automatic put_random_string();
        int kind;
        int mo;
        int dd;
        int hh;
        int mi;
        int n;
        begin
            kind = $urandom_range(0, 99);
            if (kind < 78)
            begin
                mo = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
                dd = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 31);
                hh = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 24);
                mi = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59);
                put_text($sformatf("%02d%02d%02d%02d", mo, dd, hh, mi));
                if ($urandom_range(0, 1))
                    put_text($sformatf("%02d", $urandom_range(0, 99)));
                case ($urandom_range(0, 9))
                    0, 1, 2: put_byte(dse_pkg::CHAR_P);
                    3:       put_byte(8'($urandom_range(0, 255)));
                    4:
                    begin
                        // terminator, then characters that must be ignored
                        put_byte(8'h00);
                        put_byte(dse_pkg::CHAR_P);
                        put_byte(8'($urandom_range(0, 255)));
                    end
                    5:
                    begin
                        repeat ($urandom_range(1, 3))
                            if (string_buf.size() > 1)
                                void'(string_buf.pop_back());
                    end
                    default: ;
                endcase
            end
            else
            begin
                n = $urandom_range(1, 12);
                repeat (n)
                begin
                    if ($urandom_range(0, 2) == 0)
                        put_byte(8'($urandom_range(0, 255)));
                    else
                        put_byte(dse_pkg::CHAR_0 + 8'($urandom_range(0, 9)));
                end
            end
        end
    endtask

    initial
    begin
        int target;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int g = 0; g < GROUPS; g++)
        begin
            // idle pattern: sender light / receiver heavy, then swapped, then none
            case (g / 2)
                0:
                begin
                    send_idle_pct = 6;
                    recv_idle_pct <= 81;
                end
                1:
                begin
                    send_idle_pct = 81;
                    recv_idle_pct <= 6;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct <= 0;
                end
            endcase

            if (g > 0)
            begin
                settle();
                case (g)
                    1:       set_config(0, -46800);
                    2:       set_config(199, 46800);
                    3:       set_config($urandom_range(0, 199), $urandom_range(0, 93600) - 46800);
                    4:       set_config(70, $urandom_range(0, 93600) - 46800);
                    default: set_config(100, -1);
                endcase
            end

            if (g == 0)
            begin
                // directed strings under the reset registers
                put_text("01010000");     send_string();   // the epoch itself
                put_text("12312359");     send_string();
                put_text("0229120096");   send_string();   // leap day
                put_text("02311200");     send_string();   // rolls into March
                put_text("01012400");     send_string();   // hour 24
                put_text("01011130p");    send_string();   // afternoon
                put_text("01011230p");    send_string();   // afternoon pushes past 23
                put_text("01012400p");    send_string();
                put_text("0101113000p");  send_string();   // afternoon after a year
                put_text("010100001");    send_string();   // half a year pair
                put_text("010100009xp");  send_string();   // broken year pair
                put_text("0101000050");   send_string();   // year before the epoch
                put_text("1231235999");   send_string();
                put_text("0101000099x");  send_string();   // character after all pairs
                put_text("01010000");
                put_byte(8'h00);
                put_text("99p");          send_string();   // text after the terminator
                put_text("1301");         send_string();   // month 13
                put_text("00010000");     send_string();   // month 0
                put_text("01320000");     send_string();   // day 32
                put_text("01012500");     send_string();   // hour 25
                put_text("01010060");     send_string();   // minute 60
                put_text("0a010000");     send_string();
                put_text("0101000a");     send_string();
                put_text("0101");         send_string();   // fields missing
                put_byte(8'h00);          send_string();
                put_byte(8'hFF);          send_string();
            end

            if (g == 4)
                hold_go <= 1'b1;           // long output stall while input keeps coming

            target = chars_sent + RANDOM_CHARS / GROUPS;
            while (chars_sent < target)
            begin
                put_random_string();
                send_string();
            end
        end

        settle();
        $display("Sent %0d characters in %0d strings under %0d register settings",
                 chars_sent, strings_sent, settings_used);
        $display("Checked %0d results, with one long output stall of %0d cycles",
                 result_count, PRESSURE_CYCLES);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
